/* hdl/cttk_pkg.sv */
// Package for the config text tokenizer: widths, record codes, lexer modes
// and byte classification helpers. No dependencies.
`default_nettype none

package cttk_pkg;

  localparam int OFF_W  = 32;
  localparam int LINE_W = 20;
  localparam int FLD_W  = 4 + 8 + 2 * OFF_W + 2 * LINE_W + 2;
  localparam int TD_W   = ((FLD_W + 7) / 8) * 8;

  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

  // record types
  localparam logic [1:0] REC_TEXT = 2'd0;
  localparam logic [1:0] REC_TOK  = 2'd1;
  localparam logic [1:0] REC_DIAG = 2'd2;

  // token kinds
  localparam logic [3:0] K_EOF     = 4'd0;
  localparam logic [3:0] K_NEWLINE = 4'd1;
  localparam logic [3:0] K_NONE    = 4'd0;
  localparam logic [3:0] K_QUOTED  = 4'd11;
  localparam logic [3:0] K_BARE    = 4'd12;

  // diagnostic codes
  localparam logic [1:0] D_CTRL     = 2'd0;
  localparam logic [1:0] D_STR_NL   = 2'd1;
  localparam logic [1:0] D_BAD_ESC  = 2'd2;
  localparam logic [1:0] D_UNCLOSED = 2'd3;

  // lexer modes
  localparam logic [2:0] M_NORMAL  = 3'd0;
  localparam logic [2:0] M_BARE    = 3'd1;
  localparam logic [2:0] M_STRING  = 3'd2;
  localparam logic [2:0] M_ESCAPE  = 3'd3;
  localparam logic [2:0] M_COMMENT = 3'd4;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef struct packed {
    logic [1:0]        typ;
    logic [3:0]        kind;
    logic [7:0]        txt;
    logic [OFF_W-1:0]  off;
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] col;
    logic [OFF_W-1:0]  len;
    logic [1:0]        diag;
  } rec_t;

  function automatic logic [3:0] struct_kind(input logic [7:0] b);
    logic [3:0] k;
    k = K_NONE;
    case (b)
      8'h7B: k = 4'd2;   // {
      8'h7D: k = 4'd3;   // }
      8'h5B: k = 4'd4;   // [
      8'h5D: k = 4'd5;   // ]
      8'h28: k = 4'd6;   // (
      8'h29: k = 4'd7;   // )
      8'h3D: k = 4'd8;   // =
      8'h2B: k = 4'd9;   // +
      8'h2C: k = 4'd10;  // ,
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic is_ctrl(input logic [7:0] b);
    return (b < CH_SPACE) || (b == CH_DEL);
  endfunction

  function automatic logic [7:0] bom_byte(input logic [1:0] i);
    logic [7:0] v;
    v = 8'h00;
    case (i)
      2'd0: v = 8'hEF;
      2'd1: v = 8'hBB;
      2'd2: v = 8'hBF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* hdl/config_text_tokenizer.sv */
// Config text tokenizer top level: input register, micro-step lexer engine,
// last-marking hold stage and output register. Depends on cttk_pkg.
`default_nettype none

// Streaming lexer for a line-oriented config format. Source bytes come in one
// request each on in_*, with in_tlast set on a closing request that carries no
// byte; that request produces the eof token and returns the block to its reset
// state. A leading EF BB BF mark is dropped (offset then starts at 3); a partial
// mark is lexed as ordinary bytes. The engine runs one micro-step per cycle, save
// when a record is ready while the hold stage and output register are both full,
// and each step produces at most one record; the step that consumes the byte may
// carry the byte's own record. Ahead of that final step, a request takes a step
// per record that comes first (a closing newline, bare or string token, a held
// slash, a diagnostic) and a step for a comment end. The first byte after a
// partial mark takes a step that starts the replay, then each held mark byte is
// lexed as its own request would be. The closing request takes a step per record
// it causes, eof included, plus a step if the source was still at its start. One
// record per source step is held back in a hold stage until the engine knows
// whether it is the last of its request, which drives out_tlast; a full output
// register does not stop the engine until a second record is ready.
module config_text_tokenizer
  import cttk_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [7:0]      in_tdata,   // [7:0] in_byte
  input  wire logic            in_tlast,   // is_end
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  // token_kind, text_byte, where_offset, where_line, where_column,
  // token_length, diag_code, zero pad (lowest first)
  output logic [TD_W-1:0]      out_tdata,
  output logic [1:0]           out_tuser,  // record_type
  output logic                 out_tlast   // last_of_run
);

  // input request register
  logic             itm_v_r, itm_end_r;
  logic [7:0]       itm_b_r;

  // lexer state
  logic [2:0]        mode_r, mode_nxt;
  logic              psl_r, psl_nxt, pcr_r, pcr_nxt, ats_r, ats_nxt, sub_r, sub_nxt;
  logic [1:0]        bom_r, bom_nxt, rp_n_r, rp_n_nxt, rp_i_r, rp_i_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt, ts_off_r, ts_off_nxt, pl_off_r, pl_off_nxt;
  logic [LINE_W-1:0] line_r, line_nxt, col_r, col_nxt;
  logic [LINE_W-1:0] ts_line_r, ts_line_nxt, ts_col_r, ts_col_nxt;
  logic [LINE_W-1:0] pl_line_r, pl_line_nxt, pl_col_r, pl_col_nxt;

  // hold stage and output register
  logic pd_v_r, pd_fin_r;
  rec_t pd_r;
  logic out_v_r, out_last_r;
  rec_t out_r;

  // engine outputs
  logic em, fin, done, feed_en, is_rp;
  rec_t er;
  logic [7:0] cb;
  logic [3:0] sk;

  logic [OFF_W-1:0]  off_inc;
  logic [LINE_W-1:0] col_inc, line_inc;

  logic mv_ok, step, pd_mv, in_acc;

  assign off_inc  = off_r + OFF_W'(1);
  assign col_inc  = (col_r == LINE_MAX) ? col_r : col_r + LINE_W'(1);
  assign line_inc = (line_r == LINE_MAX) ? line_r : line_r + LINE_W'(1);

  assign is_rp = !ats_r && (rp_i_r != rp_n_r);
  assign sk    = struct_kind(cb);

  // one micro-step of the lexer
  always_comb begin
    mode_nxt = mode_r;  psl_nxt = psl_r;  pcr_nxt = pcr_r;  ats_nxt = ats_r;
    sub_nxt  = sub_r;   bom_nxt = bom_r;  rp_n_nxt = rp_n_r; rp_i_nxt = rp_i_r;
    off_nxt  = off_r;   line_nxt = line_r; col_nxt = col_r;
    ts_off_nxt = ts_off_r; ts_line_nxt = ts_line_r; ts_col_nxt = ts_col_r;
    pl_off_nxt = pl_off_r; pl_line_nxt = pl_line_r; pl_col_nxt = pl_col_r;
    em = 1'b0; fin = 1'b0; done = 1'b0; feed_en = 1'b0;
    er = '0;
    cb = is_rp ? bom_byte(rp_i_r) : itm_b_r;

    if (ats_r) begin
      if (!itm_end_r && bom_r != 2'd3 && itm_b_r == bom_byte(bom_r)) begin
        if (bom_r == 2'd2) begin
          off_nxt = OFF_W'(3);
          bom_nxt = 2'd0;
          ats_nxt = 1'b0;
        end else begin
          bom_nxt = bom_r + 2'd1;
        end
        fin = 1'b1;
      end else begin
        // mismatch: lex the held mark bytes first
        ats_nxt  = 1'b0;
        rp_n_nxt = bom_r;
        rp_i_nxt = 2'd0;
        bom_nxt  = 2'd0;
      end
    end else if (is_rp || !itm_end_r) begin
      feed_en = 1'b1;
    end else begin
      // closing sequence at end of source
      if (pcr_r) begin
        pcr_nxt = 1'b0;
        em = 1'b1;
        er.typ = REC_TOK; er.kind = K_NEWLINE;
        er.off = ts_off_r; er.line = ts_line_r; er.col = ts_col_r;
        er.len = off_r - ts_off_r;
        line_nxt = line_inc; col_nxt = LINE_W'(1);
      end else if (psl_r) begin
        psl_nxt = 1'b0;
        em = 1'b1;
        er.typ = REC_TEXT; er.kind = K_BARE; er.txt = CH_SLASH;
        if (mode_r == M_NORMAL) begin
          ts_off_nxt = pl_off_r; ts_line_nxt = pl_line_r; ts_col_nxt = pl_col_r;
          mode_nxt = M_BARE;
          er.off = pl_off_r; er.line = pl_line_r; er.col = pl_col_r;
        end else begin
          er.off = ts_off_r; er.line = ts_line_r; er.col = ts_col_r;
        end
      end else if (mode_r == M_BARE) begin
        em = 1'b1;
        er.typ = REC_TOK; er.kind = K_BARE;
        er.off = ts_off_r; er.line = ts_line_r; er.col = ts_col_r;
        er.len = off_r - ts_off_r;
        mode_nxt = M_NORMAL;
      end else if (mode_r == M_STRING || mode_r == M_ESCAPE) begin
        em = 1'b1;
        er.off = ts_off_r; er.line = ts_line_r; er.col = ts_col_r;
        if (!sub_r) begin
          er.typ = REC_DIAG; er.diag = D_UNCLOSED;
          sub_nxt = 1'b1;
        end else begin
          er.typ = REC_TOK; er.kind = K_QUOTED;
          er.len = off_r - ts_off_r;
          mode_nxt = M_NORMAL;
          sub_nxt = 1'b0;
        end
      end else begin
        em = 1'b1;
        er.typ = REC_TOK; er.kind = K_EOF;
        er.off = off_r; er.line = line_r; er.col = col_r;
        fin = 1'b1;
        mode_nxt = M_NORMAL; psl_nxt = 1'b0; pcr_nxt = 1'b0; ats_nxt = 1'b1;
        sub_nxt = 1'b0; bom_nxt = 2'd0; rp_n_nxt = 2'd0; rp_i_nxt = 2'd0;
        off_nxt = '0; line_nxt = LINE_W'(1); col_nxt = LINE_W'(1);
        ts_off_nxt = '0; ts_line_nxt = LINE_W'(1); ts_col_nxt = LINE_W'(1);
        pl_off_nxt = '0; pl_line_nxt = LINE_W'(1); pl_col_nxt = LINE_W'(1);
      end
    end

    if (feed_en) begin
      if (pcr_r) begin
        pcr_nxt = 1'b0;
        em = 1'b1;
        er.typ = REC_TOK; er.kind = K_NEWLINE;
        er.off = ts_off_r; er.line = ts_line_r; er.col = ts_col_r;
        line_nxt = line_inc; col_nxt = LINE_W'(1);
        if (cb == CH_LF) begin
          // CRLF: the LF belongs to the token
          off_nxt = off_inc;
          er.len = off_inc - ts_off_r;
          done = 1'b1;
        end else begin
          er.len = off_r - ts_off_r;
        end
      end else if (psl_r) begin
        psl_nxt = 1'b0;
        if (cb == CH_SLASH) begin
          if (mode_r == M_BARE) begin
            em = 1'b1;
            er.typ = REC_TOK; er.kind = K_BARE;
            er.off = ts_off_r; er.line = ts_line_r; er.col = ts_col_r;
            er.len = pl_off_r - ts_off_r;
          end
          mode_nxt = M_COMMENT;
          off_nxt = off_inc; col_nxt = col_inc;
          done = 1'b1;
        end else begin
          em = 1'b1;
          er.typ = REC_TEXT; er.kind = K_BARE; er.txt = CH_SLASH;
          if (mode_r == M_NORMAL) begin
            ts_off_nxt = pl_off_r; ts_line_nxt = pl_line_r; ts_col_nxt = pl_col_r;
            mode_nxt = M_BARE;
            er.off = pl_off_r; er.line = pl_line_r; er.col = pl_col_r;
          end else begin
            er.off = ts_off_r; er.line = ts_line_r; er.col = ts_col_r;
          end
        end
      end else begin
        case (mode_r)
          M_COMMENT: begin
            if (cb != CH_CR && cb != CH_LF) begin
              off_nxt = off_inc; col_nxt = col_inc;
              done = 1'b1;
            end else begin
              mode_nxt = M_NORMAL;
            end
          end
          M_ESCAPE: begin
            em = 1'b1;
            if (cb != CH_BSL && cb != CH_QUOTE && cb != 8'h6E && cb != 8'h72 &&
                cb != 8'h74 && !sub_r) begin
              er.typ = REC_DIAG; er.diag = D_BAD_ESC;
              er.off = pl_off_r; er.line = pl_line_r; er.col = pl_col_r;
              sub_nxt = 1'b1;
            end else begin
              er.typ = REC_TEXT; er.kind = K_QUOTED;
              er.off = ts_off_r; er.line = ts_line_r; er.col = ts_col_r;
              case (cb)
                8'h6E:   er.txt = CH_LF;
                8'h72:   er.txt = CH_CR;
                8'h74:   er.txt = CH_TAB;
                default: er.txt = cb;
              endcase
              off_nxt = off_inc; col_nxt = col_inc;
              mode_nxt = M_STRING;
              sub_nxt = 1'b0;
              done = 1'b1;
            end
          end
          M_STRING: begin
            if (cb == CH_QUOTE) begin
              em = 1'b1;
              er.typ = REC_TOK; er.kind = K_QUOTED;
              er.off = ts_off_r; er.line = ts_line_r; er.col = ts_col_r;
              er.len = off_inc - ts_off_r;
              off_nxt = off_inc; col_nxt = col_inc;
              mode_nxt = M_NORMAL;
              done = 1'b1;
            end else if (cb == CH_CR || cb == CH_LF) begin
              // diagnostic, then the string token; the newline is lexed after
              em = 1'b1;
              if (!sub_r) begin
                er.typ = REC_DIAG; er.diag = D_STR_NL;
                er.off = off_r; er.line = line_r; er.col = col_r;
                sub_nxt = 1'b1;
              end else begin
                er.typ = REC_TOK; er.kind = K_QUOTED;
                er.off = ts_off_r; er.line = ts_line_r; er.col = ts_col_r;
                er.len = off_r - ts_off_r;
                mode_nxt = M_NORMAL;
                sub_nxt = 1'b0;
              end
            end else if (cb == CH_BSL) begin
              pl_off_nxt = off_r; pl_line_nxt = line_r; pl_col_nxt = col_r;
              off_nxt = off_inc; col_nxt = col_inc;
              mode_nxt = M_ESCAPE;
              done = 1'b1;
            end else begin
              em = 1'b1;
              er.typ = REC_TEXT; er.kind = K_QUOTED; er.txt = cb;
              er.off = ts_off_r; er.line = ts_line_r; er.col = ts_col_r;
              off_nxt = off_inc; col_nxt = col_inc;
              done = 1'b1;
            end
          end
          M_BARE: begin
            if (cb == CH_SPACE || sk != K_NONE || is_ctrl(cb)) begin
              em = 1'b1;
              er.typ = REC_TOK; er.kind = K_BARE;
              er.off = ts_off_r; er.line = ts_line_r; er.col = ts_col_r;
              er.len = off_r - ts_off_r;
              mode_nxt = M_NORMAL;
            end else if (cb == CH_SLASH) begin
              pl_off_nxt = off_r; pl_line_nxt = line_r; pl_col_nxt = col_r;
              psl_nxt = 1'b1;
              off_nxt = off_inc; col_nxt = col_inc;
              done = 1'b1;
            end else begin
              em = 1'b1;
              er.typ = REC_TEXT; er.kind = K_BARE; er.txt = cb;
              er.off = ts_off_r; er.line = ts_line_r; er.col = ts_col_r;
              off_nxt = off_inc; col_nxt = col_inc;
              done = 1'b1;
            end
          end
          default: begin
            // normal mode
            mode_nxt = M_NORMAL;
            done = 1'b1;
            off_nxt = off_inc; col_nxt = col_inc;
            if (cb == CH_SPACE || cb == CH_TAB) begin
              // skip
            end else if (cb == CH_CR) begin
              ts_off_nxt = off_r; ts_line_nxt = line_r; ts_col_nxt = col_r;
              pcr_nxt = 1'b1;
            end else if (cb == CH_LF) begin
              ts_off_nxt = off_r; ts_line_nxt = line_r; ts_col_nxt = col_r;
              em = 1'b1;
              er.typ = REC_TOK; er.kind = K_NEWLINE;
              er.off = off_r; er.line = line_r; er.col = col_r;
              er.len = OFF_W'(1);
              line_nxt = line_inc; col_nxt = LINE_W'(1);
            end else if (cb == CH_SLASH) begin
              pl_off_nxt = off_r; pl_line_nxt = line_r; pl_col_nxt = col_r;
              psl_nxt = 1'b1;
            end else if (cb == CH_QUOTE) begin
              ts_off_nxt = off_r; ts_line_nxt = line_r; ts_col_nxt = col_r;
              mode_nxt = M_STRING;
            end else if (sk != K_NONE) begin
              em = 1'b1;
              er.typ = REC_TOK; er.kind = sk;
              er.off = off_r; er.line = line_r; er.col = col_r;
              er.len = OFF_W'(1);
            end else if (is_ctrl(cb)) begin
              em = 1'b1;
              er.typ = REC_DIAG; er.diag = D_CTRL;
              er.off = off_r; er.line = line_r; er.col = col_r;
            end else begin
              ts_off_nxt = off_r; ts_line_nxt = line_r; ts_col_nxt = col_r;
              em = 1'b1;
              er.typ = REC_TEXT; er.kind = K_BARE; er.txt = cb;
              er.off = off_r; er.line = line_r; er.col = col_r;
              mode_nxt = M_BARE;
            end
          end
        endcase
      end
      if (done) begin
        if (is_rp) rp_i_nxt = rp_i_r + 2'd1;
        else       fin = 1'b1;
      end
    end
  end

  // handshakes: a new record needs the hold stage free or draining
  assign mv_ok  = !out_v_r || out_tready;
  assign step   = itm_v_r && (!em || !pd_v_r || mv_ok);
  assign pd_mv  = pd_v_r && mv_ok && ((step && em) || pd_fin_r);
  assign in_tready = !itm_v_r || (step && fin);
  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      itm_v_r <= 1'b0;
      mode_r <= M_NORMAL; psl_r <= 1'b0; pcr_r <= 1'b0; ats_r <= 1'b1;
      sub_r <= 1'b0; bom_r <= 2'd0; rp_n_r <= 2'd0; rp_i_r <= 2'd0;
      off_r <= '0; line_r <= LINE_W'(1); col_r <= LINE_W'(1);
      ts_off_r <= '0; ts_line_r <= LINE_W'(1); ts_col_r <= LINE_W'(1);
      pl_off_r <= '0; pl_line_r <= LINE_W'(1); pl_col_r <= LINE_W'(1);
      pd_v_r <= 1'b0; pd_fin_r <= 1'b0;
      out_v_r <= 1'b0; out_last_r <= 1'b0;
    end else begin
      if (in_acc) itm_v_r <= 1'b1;
      else if (step && fin) itm_v_r <= 1'b0;

      if (step) begin
        mode_r <= mode_nxt; psl_r <= psl_nxt; pcr_r <= pcr_nxt; ats_r <= ats_nxt;
        sub_r <= sub_nxt; bom_r <= bom_nxt; rp_n_r <= rp_n_nxt; rp_i_r <= rp_i_nxt;
        off_r <= off_nxt; line_r <= line_nxt; col_r <= col_nxt;
        ts_off_r <= ts_off_nxt; ts_line_r <= ts_line_nxt; ts_col_r <= ts_col_nxt;
        pl_off_r <= pl_off_nxt; pl_line_r <= pl_line_nxt; pl_col_r <= pl_col_nxt;
      end

      // hold stage: last-of-request mark is set once the request finishes
      if (step && em) begin
        pd_v_r   <= 1'b1;
        pd_fin_r <= fin;
      end else if (pd_mv) begin
        pd_v_r   <= 1'b0;
        pd_fin_r <= 1'b0;
      end else if (step && fin && pd_v_r) begin
        pd_fin_r <= 1'b1;
      end

      if (pd_mv) begin
        out_v_r    <= 1'b1;
        out_last_r <= pd_fin_r;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      itm_b_r   <= in_tdata;
      itm_end_r <= in_tlast;
    end
    if (step && em) pd_r <= er;
    if (pd_mv) out_r <= pd_r;
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_r.typ;
  assign out_tdata  = TD_W'({out_r.diag, out_r.len, out_r.col, out_r.line,
                             out_r.off, out_r.txt, out_r.kind});

endmodule

`default_nettype wire
